### rtl/core/g722e_pkg.sv
// Shared types, command codes and coefficient tables for the 64 kbit/s
// sub-band ADPCM encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package g722e_pkg;

  localparam int QMF_TAPS = 12;

  // Datapath operation codes issued by the controller
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_QMF   = 4'd2;
  localparam logic [3:0] OP_SPLIT = 4'd3;
  localparam logic [3:0] OP_ERR   = 4'd4;
  localparam logic [3:0] OP_QUANT = 4'd5;
  localparam logic [3:0] OP_DQ    = 4'd6;
  localparam logic [3:0] OP_LOG   = 4'd7;
  localparam logic [3:0] OP_POLE1 = 4'd8;
  localparam logic [3:0] OP_POLE0 = 4'd9;
  localparam logic [3:0] OP_SP1   = 4'd10;
  localparam logic [3:0] OP_SP2   = 4'd11;
  localparam logic [3:0] OP_Z1    = 4'd12;
  localparam logic [3:0] OP_Z2    = 4'd13;
  localparam logic [3:0] OP_FIN   = 4'd14;

  localparam logic [4:0] QUANT_LAST = 5'd29;
  localparam logic [4:0] QUANT_OUTER = 5'd30;
  localparam logic [14:0] LOG_MAX_LOW  = 15'd18432;
  localparam logic [14:0] LOG_MAX_HIGH = 15'd22528;
  localparam logic [14:0] STEP_RESET_LOW  = 15'd32;
  localparam logic [14:0] STEP_RESET_HIGH = 15'd8;

  typedef struct packed {
    logic [3:0] op;
    logic       band;
    logic [4:0] cnt;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic quant_done;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) r = 16'sh7fff;
    else if (v < -21'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [12:0] coef_fwd(input logic [3:0] i);
    logic signed [12:0] c;
    case (i)
      4'd0: c = 13'sd3;      4'd1: c = -13'sd11;   4'd2: c = 13'sd12;
      4'd3: c = 13'sd32;     4'd4: c = -13'sd210;  4'd5: c = 13'sd951;
      4'd6: c = 13'sd3876;   4'd7: c = -13'sd805;  4'd8: c = 13'sd362;
      4'd9: c = -13'sd156;   4'd10: c = 13'sd53;   4'd11: c = -13'sd11;
      default: c = 13'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [12:0] coef_rev(input logic [3:0] i);
    logic signed [12:0] c;
    case (i)
      4'd0: c = -13'sd11;    4'd1: c = 13'sd53;    4'd2: c = -13'sd156;
      4'd3: c = 13'sd362;    4'd4: c = -13'sd805;  4'd5: c = 13'sd3876;
      4'd6: c = 13'sd951;    4'd7: c = -13'sd210;  4'd8: c = 13'sd32;
      4'd9: c = 13'sd12;     4'd10: c = -13'sd11;  4'd11: c = 13'sd3;
      default: c = 13'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] qm2(input logic [1:0] i);
    logic signed [15:0] c;
    case (i)
      2'd0: c = -16'sd7408;  2'd1: c = -16'sd1616;
      2'd2: c = 16'sd7408;   default: c = 16'sd1616;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] qm4(input logic [3:0] i);
    logic signed [15:0] c;
    case (i)
      4'd0: c = 16'sd0;       4'd1: c = -16'sd20456;  4'd2: c = -16'sd12896;
      4'd3: c = -16'sd8968;   4'd4: c = -16'sd6288;   4'd5: c = -16'sd4240;
      4'd6: c = -16'sd2584;   4'd7: c = -16'sd1200;   4'd8: c = 16'sd20456;
      4'd9: c = 16'sd12896;   4'd10: c = 16'sd8968;   4'd11: c = 16'sd6288;
      4'd12: c = 16'sd4240;   4'd13: c = 16'sd2584;   4'd14: c = 16'sd1200;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [11:0] q6(input logic [4:0] i);
    logic [11:0] c;
    case (i)
      5'd1: c = 12'd35;    5'd2: c = 12'd72;    5'd3: c = 12'd110;   5'd4: c = 12'd150;
      5'd5: c = 12'd190;   5'd6: c = 12'd233;   5'd7: c = 12'd276;   5'd8: c = 12'd323;
      5'd9: c = 12'd370;   5'd10: c = 12'd422;  5'd11: c = 12'd473;  5'd12: c = 12'd530;
      5'd13: c = 12'd587;  5'd14: c = 12'd650;  5'd15: c = 12'd714;  5'd16: c = 12'd786;
      5'd17: c = 12'd858;  5'd18: c = 12'd940;  5'd19: c = 12'd1023; 5'd20: c = 12'd1121;
      5'd21: c = 12'd1219; 5'd22: c = 12'd1339; 5'd23: c = 12'd1458; 5'd24: c = 12'd1612;
      5'd25: c = 12'd1765; 5'd26: c = 12'd1980; 5'd27: c = 12'd2195; 5'd28: c = 12'd2557;
      5'd29: c = 12'd2919;
      default: c = 12'd0;
    endcase
    return c;
  endfunction

  function automatic logic [11:0] ilb(input logic [4:0] i);
    logic [11:0] c;
    case (i)
      5'd0: c = 12'd2048;  5'd1: c = 12'd2093;  5'd2: c = 12'd2139;  5'd3: c = 12'd2186;
      5'd4: c = 12'd2233;  5'd5: c = 12'd2282;  5'd6: c = 12'd2332;  5'd7: c = 12'd2383;
      5'd8: c = 12'd2435;  5'd9: c = 12'd2489;  5'd10: c = 12'd2543; 5'd11: c = 12'd2599;
      5'd12: c = 12'd2656; 5'd13: c = 12'd2714; 5'd14: c = 12'd2774; 5'd15: c = 12'd2834;
      5'd16: c = 12'd2896; 5'd17: c = 12'd2960; 5'd18: c = 12'd3025; 5'd19: c = 12'd3091;
      5'd20: c = 12'd3158; 5'd21: c = 12'd3228; 5'd22: c = 12'd3298; 5'd23: c = 12'd3371;
      5'd24: c = 12'd3444; 5'd25: c = 12'd3520; 5'd26: c = 12'd3597; 5'd27: c = 12'd3676;
      5'd28: c = 12'd3756; 5'd29: c = 12'd3838; 5'd30: c = 12'd3922;
      default: c = 12'd4008;
    endcase
    return c;
  endfunction

  // Low-band code for a negative / non-negative error at decision level i
  function automatic logic [5:0] neg6(input logic [4:0] i);
    logic [5:0] c;
    case (i)
      5'd0: c = 6'd0;
      5'd1: c = 6'd63;
      5'd2: c = 6'd62;
      5'd31: c = 6'd0;
      default: c = 6'(7'd34 - {2'b00, i});
    endcase
    return c;
  endfunction

  function automatic logic [5:0] pos6(input logic [4:0] i);
    logic [5:0] c;
    case (i)
      5'd0: c = 6'd0;
      5'd31: c = 6'd0;
      default: c = 6'(7'd62 - {2'b00, i});
    endcase
    return c;
  endfunction

  function automatic logic [2:0] rl42(input logic [3:0] i);
    logic [2:0] c;
    case (i)
      4'd0: c = 3'd0;
      4'd15: c = 3'd0;
      default: c = (i < 4'd8) ? 3'(4'd8 - i) : 3'(4'd15 - i);
    endcase
    return c;
  endfunction

  function automatic logic signed [12:0] wl(input logic [2:0] i);
    logic signed [12:0] c;
    case (i)
      3'd0: c = -13'sd60;  3'd1: c = -13'sd30;  3'd2: c = 13'sd58;   3'd3: c = 13'sd172;
      3'd4: c = 13'sd334;  3'd5: c = 13'sd538;  3'd6: c = 13'sd1198; default: c = 13'sd3042;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] rh2(input logic [1:0] i);
    return i[0] ? 2'd1 : 2'd2;
  endfunction

  function automatic logic signed [12:0] wh(input logic [1:0] i);
    logic signed [12:0] c;
    case (i)
      2'd1: c = -13'sd214;
      2'd2: c = 13'sd798;
      default: c = 13'sd0;
    endcase
    return c;
  endfunction

  // Step size from log scale: table lookup, then a right shift set by the exponent
  function automatic logic [14:0] step_from_log(input logic [14:0] nb, input logic [3:0] bias);
    logic [4:0] sh;
    logic [12:0] v;
    sh = 5'(bias) + 5'd1 - {1'b0, nb[14:11]};
    v = {ilb(nb[10:6]), 1'b0} >> sh;
    return {v, 2'b00};
  endfunction

endpackage

`default_nettype wire

### rtl/core/g722e_ctrl.sv
// Sequencer of the sub-band ADPCM encoder, uses g722e_pkg: walks QMF, then
// low and high band steps, one datapath command per cycle bar the emit wait.
`timescale 1ns / 1ps
`default_nettype none

module g722e_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_free,
  input  wire g722e_pkg::status_t  status,
  output g722e_pkg::cmd_t          cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QMF   = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_ERR   = 4'd3;
  localparam logic [3:0] S_QUANT = 4'd4;
  localparam logic [3:0] S_DQ    = 4'd5;
  localparam logic [3:0] S_LOG   = 4'd6;
  localparam logic [3:0] S_POLE1 = 4'd7;
  localparam logic [3:0] S_POLE0 = 4'd8;
  localparam logic [3:0] S_SP1   = 4'd9;
  localparam logic [3:0] S_SP2   = 4'd10;
  localparam logic [3:0] S_Z1    = 4'd11;
  localparam logic [3:0] S_Z2    = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state, state_next;
  logic       band, band_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    band_next = band;
    cnt_next = cnt;
    cmd.op = g722e_pkg::OP_NOP;
    cmd.emit = 1'b0;
    cmd.band = band;
    cmd.cnt = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = g722e_pkg::OP_LOAD;
          state_next = S_QMF;
          cnt_next = 5'd0;
        end
      end
      S_QMF: begin
        cmd.op = g722e_pkg::OP_QMF;
        if (cnt == 5'(g722e_pkg::QMF_TAPS - 1)) state_next = S_SPLIT;
        else cnt_next = cnt + 5'd1;
      end
      S_SPLIT: begin
        cmd.op = g722e_pkg::OP_SPLIT;
        band_next = 1'b0;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op = g722e_pkg::OP_ERR;
        cnt_next = band ? 5'd0 : 5'd1;
        state_next = S_QUANT;
      end
      S_QUANT: begin
        cmd.op = g722e_pkg::OP_QUANT;
        if (status.quant_done) state_next = S_DQ;
        else cnt_next = cnt + 5'd1;
      end
      S_DQ: begin
        cmd.op = g722e_pkg::OP_DQ;
        state_next = S_LOG;
      end
      S_LOG: begin
        cmd.op = g722e_pkg::OP_LOG;
        state_next = S_POLE1;
      end
      S_POLE1: begin
        cmd.op = g722e_pkg::OP_POLE1;
        state_next = S_POLE0;
      end
      S_POLE0: begin
        cmd.op = g722e_pkg::OP_POLE0;
        state_next = S_SP1;
      end
      S_SP1: begin
        cmd.op = g722e_pkg::OP_SP1;
        state_next = S_SP2;
      end
      S_SP2: begin
        cmd.op = g722e_pkg::OP_SP2;
        cnt_next = 5'd5;
        state_next = S_Z1;
      end
      S_Z1: begin
        cmd.op = g722e_pkg::OP_Z1;
        state_next = S_Z2;
      end
      S_Z2: begin
        cmd.op = g722e_pkg::OP_Z2;
        if (cnt == 5'd0) state_next = S_FIN;
        else begin
          cnt_next = cnt - 5'd1;
          state_next = S_Z1;
        end
      end
      S_FIN: begin
        cmd.op = g722e_pkg::OP_FIN;
        if (band) state_next = S_DONE;
        else begin
          band_next = 1'b1;
          state_next = S_ERR;
        end
      end
      S_DONE: begin
        // hold until the output register can take the code
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      band <= 1'b0;
      cnt <= 5'd0;
    end else begin
      state <= state_next;
      band <= band_next;
      cnt <= cnt_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_QMF && cnt == 5'd0))
    else $error("accepted pair did not start the filter pass");
  a_quant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QUANT && !band) |-> (cnt >= 5'd1 && cnt <= g722e_pkg::QUANT_LAST))
    else $error("low-band level search out of range");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("code emitted into a full output register");

endmodule

`default_nettype wire

### rtl/core/g722e_dp.sv
// Datapath of the sub-band ADPCM encoder: QMF histories, both band states, a
// shared and a QMF multiplier and saturating predictor math. Uses g722e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module g722e_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire g722e_pkg::cmd_t    cmd,
  input  wire logic signed [15:0] sample_even,
  input  wire logic signed [15:0] sample_odd,
  output g722e_pkg::status_t      status,
  output logic [7:0]              code_byte
);

  // filter state
  logic signed [15:0] he [12];
  logic signed [15:0] ho [12];
  logic [3:0]         pos;
  logic signed [31:0] acc_o, acc_e;
  logic signed [15:0] xl, xh;

  // band state, index 0 low band, 1 high band
  logic signed [15:0] s_est [2];
  logic signed [15:0] z_est [2];
  logic signed [15:0] last  [2];
  logic signed [15:0] a0    [2];
  logic signed [15:0] a1    [2];
  logic signed [15:0] p0    [2];
  logic signed [15:0] p1    [2];
  logic signed [15:0] d     [14];
  logic signed [15:0] z     [12];
  logic [14:0]        ls    [2];
  logic [14:0]        stp   [2];

  // per-pair scratch
  logic               e_neg;
  logic [14:0]        mag;
  logic [5:0]         code_low;
  logic [1:0]         code_high;
  logic signed [15:0] dx, r, pr, ap0, ap1, spt1, sp;
  logic signed [19:0] sz;

  logic               b;
  logic [3:0]         cnt4;
  logic [4:0]         hsum;
  logic [3:0]         hidx;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [28:0] prod_o;
  logic signed [32:0] sum33, dif33;
  logic [3:0]         zidx, dridx;
  logic signed [15:0] zr, dr;
  logic signed [15:0] xb, e_c, rr, ll, dd, t1p, t2p, t3w, t3c, ap0s, ap0c, lim;
  logic signed [16:0] t2w;
  logic signed [20:0] t3sum;
  logic [14:0]        thr;
  logic               hit, diff0, diff1;
  logic [4:0]         i_fin;
  logic signed [15:0] qv;
  logic signed [12:0] wv;
  logic signed [16:0] nb17;
  logic [14:0]        nbc;
  logic [7:0]         t1z;
  logic signed [15:0] t2z, zs, sze;

  assign b = cmd.band;
  assign cnt4 = cmd.cnt[3:0];
  assign hsum = {1'b0, pos} + {1'b0, cnt4};
  assign hidx = (hsum >= 5'(g722e_pkg::QMF_TAPS)) ? 4'(hsum - 5'(g722e_pkg::QMF_TAPS))
                                                  : hsum[3:0];
  assign zidx = (b ? 4'd6 : 4'd0) + cnt4;
  assign dridx = (b ? 4'd7 : 4'd0) + cnt4 + ((cmd.op == g722e_pkg::OP_Z1) ? 4'd1 : 4'd0);
  assign zr = z[zidx];
  assign dr = d[dridx];

  always_comb begin
    xb = b ? xh : xl;
    e_c = g722e_pkg::sat16(21'(xb) - 21'(s_est[b]));
    rr = g722e_pkg::sat16(21'(r) + 21'(r));
    ll = g722e_pkg::sat16(21'(last[b]) + 21'(last[b]));
    dd = g722e_pkg::sat16(21'(dr) + 21'(dr));
    qv = b ? g722e_pkg::qm2(code_high) : g722e_pkg::qm4(code_low[5:2]);
    mul_a = 17'sd0;
    mul_b = 17'sd0;
    case (cmd.op)
      g722e_pkg::OP_QMF: begin
        mul_a = 17'(he[hidx]);
        mul_b = 17'(g722e_pkg::coef_fwd(cnt4));
      end
      g722e_pkg::OP_QUANT: begin
        mul_a = b ? 17'sd564 : {5'b0, g722e_pkg::q6(cmd.cnt)};
        mul_b = {2'b00, stp[b]};
      end
      g722e_pkg::OP_DQ: begin
        mul_a = {2'b00, stp[b]};
        mul_b = 17'(qv);
      end
      g722e_pkg::OP_LOG: begin
        mul_a = {2'b00, ls[b]};
        mul_b = 17'sd127;
      end
      g722e_pkg::OP_POLE1: begin
        mul_a = 17'(a1[b]);
        mul_b = 17'sd32512;
      end
      g722e_pkg::OP_POLE0: begin
        mul_a = 17'(a0[b]);
        mul_b = 17'sd32640;
      end
      g722e_pkg::OP_SP1: begin
        mul_a = 17'(ap0);
        mul_b = 17'(rr);
      end
      g722e_pkg::OP_SP2: begin
        mul_a = 17'(ap1);
        mul_b = 17'(ll);
      end
      g722e_pkg::OP_Z1: begin
        mul_a = 17'(zr);
        mul_b = 17'sd32640;
      end
      g722e_pkg::OP_Z2: begin
        mul_a = 17'(zr);
        mul_b = 17'(dd);
      end
      default: begin
        mul_a = 17'sd0;
        mul_b = 17'sd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign prod_o = ho[hidx] * g722e_pkg::coef_rev(cnt4);
  assign sum33 = 33'(acc_e) + 33'(acc_o);
  assign dif33 = 33'(acc_e) - 33'(acc_o);

  // quantizer compare
  assign thr = prod[26:12];
  assign hit = ({1'b0, mag} < {1'b0, thr});
  assign i_fin = hit ? cmd.cnt : g722e_pkg::QUANT_OUTER;
  assign status.quant_done = b || hit || (cmd.cnt == g722e_pkg::QUANT_LAST);

  // log-scale adaptation
  assign wv = b ? g722e_pkg::wh(g722e_pkg::rh2(code_high))
                : g722e_pkg::wl(g722e_pkg::rl42(code_low[5:2]));
  assign nb17 = $signed({2'b00, prod[21:7]}) + 17'(wv);
  always_comb begin
    if (nb17 < 17'sd0) nbc = 15'd0;
    else if (!b && nb17 > $signed({2'b00, g722e_pkg::LOG_MAX_LOW}))
      nbc = g722e_pkg::LOG_MAX_LOW;
    else if (b && nb17 > $signed({2'b00, g722e_pkg::LOG_MAX_HIGH}))
      nbc = g722e_pkg::LOG_MAX_HIGH;
    else nbc = nb17[14:0];
  end

  // pole updates
  assign diff0 = pr[15] ^ p0[b][15];
  assign diff1 = pr[15] ^ p1[b][15];
  always_comb begin
    t1p = g722e_pkg::sat16(21'($signed({a0[b], 2'b00})));
    t2w = diff0 ? 17'(t1p) : -17'(t1p);
    t2p = (t2w > 17'sd32767) ? 16'sh7fff : t2w[15:0];
    t3sum = (diff1 ? -21'sd128 : 21'sd128) + 21'(t2p >>> 7) + 21'($signed(prod[33:15]));
    t3w = t3sum[15:0];
    if (t3w > 16'sd12288) t3c = 16'sd12288;
    else if (t3w < -16'sd12288) t3c = -16'sd12288;
    else t3c = t3w;
    ap0s = g722e_pkg::sat16((diff0 ? -21'sd192 : 21'sd192) + 21'($signed(prod[30:15])));
    lim = g722e_pkg::sat16(21'sd15360 - 21'(ap1));
    if (ap0s > lim) ap0c = lim;
    else if (ap0s < -lim) ap0c = -lim;
    else ap0c = ap0s;
  end

  // zero updates
  assign t1z = (dx == 16'sd0) ? 8'd0 : 8'd128;
  assign t2z = (dr[15] ^ dx[15]) ? -$signed({8'b0, t1z}) : $signed({8'b0, t1z});
  assign zs = g722e_pkg::sat16(21'(t2z) + 21'($signed(prod[30:15])));
  assign sze = g722e_pkg::sat16(21'(sz));

  assign code_byte = {code_high, code_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < g722e_pkg::QMF_TAPS; k++) begin
        he[k] <= '0;
        ho[k] <= '0;
        z[k] <= '0;
      end
      for (int k = 0; k < 14; k++) d[k] <= '0;
      for (int k = 0; k < 2; k++) begin
        s_est[k] <= '0;
        z_est[k] <= '0;
        last[k] <= '0;
        a0[k] <= '0;
        a1[k] <= '0;
        p0[k] <= '0;
        p1[k] <= '0;
        ls[k] <= '0;
      end
      stp[0] <= g722e_pkg::STEP_RESET_LOW;
      stp[1] <= g722e_pkg::STEP_RESET_HIGH;
      pos <= 4'd0;
    end else begin
      case (cmd.op)
        g722e_pkg::OP_LOAD: begin
          he[pos] <= sample_even;
          ho[pos] <= sample_odd;
          pos <= (pos == 4'(g722e_pkg::QMF_TAPS - 1)) ? 4'd0 : pos + 4'd1;
          acc_o <= '0;
          acc_e <= '0;
        end
        g722e_pkg::OP_QMF: begin
          acc_o <= acc_o + 32'(prod);
          acc_e <= acc_e + 32'(prod_o);
        end
        g722e_pkg::OP_SPLIT: begin
          xl <= sum33[29:14];
          xh <= dif33[29:14];
        end
        g722e_pkg::OP_ERR: begin
          e_neg <= e_c[15];
          mag <= e_c[15] ? ~e_c[14:0] : e_c[14:0];
        end
        g722e_pkg::OP_QUANT: begin
          if (b) begin
            if (hit) code_high <= e_neg ? 2'd1 : 2'd3;
            else code_high <= e_neg ? 2'd0 : 2'd2;
          end else if (status.quant_done) begin
            code_low <= e_neg ? g722e_pkg::neg6(i_fin) : g722e_pkg::pos6(i_fin);
          end
        end
        g722e_pkg::OP_DQ: dx <= prod[30:15];
        g722e_pkg::OP_LOG: begin
          ls[b] <= nbc;
          stp[b] <= g722e_pkg::step_from_log(nbc, b ? 4'd10 : 4'd8);
          r <= g722e_pkg::sat16(21'(s_est[b]) + 21'(dx));
          pr <= g722e_pkg::sat16(21'(z_est[b]) + 21'(dx));
        end
        g722e_pkg::OP_POLE1: ap1 <= t3c;
        g722e_pkg::OP_POLE0: ap0 <= ap0c;
        g722e_pkg::OP_SP1: spt1 <= prod[30:15];
        g722e_pkg::OP_SP2: begin
          sp <= g722e_pkg::sat16(21'(spt1) + 21'($signed(prod[30:15])));
          last[b] <= r;
          a1[b] <= ap1;
          a0[b] <= ap0;
          p1[b] <= p0[b];
          p0[b] <= pr;
          d[b ? 4'd7 : 4'd0] <= dx;
          sz <= '0;
        end
        g722e_pkg::OP_Z1: z[zidx] <= zs;
        g722e_pkg::OP_Z2: begin
          sz <= sz + 20'($signed(prod[33:15]));
          d[dridx + 4'd1] <= dr;
        end
        g722e_pkg::OP_FIN: begin
          z_est[b] <= sze;
          s_est[b] <= g722e_pkg::sat16(21'(sp) + 21'(sze));
        end
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < 4'(g722e_pkg::QMF_TAPS))
    else $error("filter write slot out of range");
  a_log_low: assert property (@(posedge clk) disable iff (rst)
    ls[0] <= g722e_pkg::LOG_MAX_LOW && ls[1] <= g722e_pkg::LOG_MAX_HIGH)
    else $error("log scale beyond its limit");
  a_pole_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == g722e_pkg::OP_SP2) |=> (a1[$past(b)] <= 16'sd12288 && a1[$past(b)] >= -16'sd12288))
    else $error("second pole coefficient beyond its limit");

endmodule

`default_nettype wire

### rtl/core/subband_adpcm_encoder_64k.sv
// Top level of the 64 kbit/s sub-band ADPCM encoder: stream ports, output
// register, controller and datapath. Uses g722e_pkg, g722e_ctrl, g722e_dp.
// The time from acceptance of a pair to the code byte on the output varies
// with the low-band level search. A new pair is taken only once the last
// code has been emitted; the shared multiplier and the 12-tap filter pass,
// walked one tap per cycle, bound the pair rate.
// Reset (rst, synchronous): clears histories, predictors and log scales, sets
// the step sizes to 32 (low band) and 8 (high band), and drops any pending code.
`timescale 1ns / 1ps
`default_nettype none

module subband_adpcm_encoder_64k (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] sample_even, [31:16] sample_odd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [7:0] code_byte
);

  g722e_pkg::cmd_t    cmd;
  g722e_pkg::status_t status;
  logic [7:0]         code_byte;
  logic               out_free;

  // the output register may take a new code when empty or being drained
  assign out_free = !m_axis_tvalid || m_axis_tready;

  g722e_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  g722e_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_even (s_axis_tdata[15:0]),
    .sample_odd  (s_axis_tdata[31:16]),
    .status      (status),
    .code_byte   (code_byte)
  );

  // Output register: load the finished code, hold it until the sink takes it.
  // The next pair is accepted while a code still waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= code_byte;
    end
  end

endmodule

`default_nettype wire
